[hw/rtl/aps_pkg.sv]
// Shared constants and request codes for the aging priority task selector.
package aps_pkg;

   localparam int MAX_TASKS_DEF  = 8;
   localparam int AVG_WINDOW_DEF = 16;
   localparam int NUM_IDS        = 8;
   localparam int ID_W           = 3;
   localparam int PRIO_W         = 8;
   localparam int TIME_W         = 32;
   localparam int DYN_W          = 16;
   localparam int WAIT_W         = 4;
   localparam int PROD_W         = PRIO_W + TIME_W;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_SCHED  = 2'd2;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;

endpackage

[hw/rtl/aps_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module aps_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [aps_pkg::TIME_W-1:0] dividend,
   input  logic [aps_pkg::TIME_W-1:0] divisor,
   output logic                       done,
   output logic [aps_pkg::TIME_W-1:0] quotient
);
   import aps_pkg::*;

   localparam int CNT_W = $clog2(TIME_W);

   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   trial;

   // One shift-and-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[TIME_W-1]} - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[TIME_W]) begin
            rem_in = trial[TIME_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[TIME_W-2:0], quo_ff[TIME_W-1]};
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/aging_priority_task_selector.sv]
// Aging priority task selector: ordered task table and schedule sequencer.
// Add and remove pass through the done state, which loads the result into the
// output register. A schedule walks the table with one shared divider: once per
// task for the age unless its period is zero, then for the moving delta sum.
// One request at a time; the next is taken once the result sits in the output.
// Reset (synchronous) empties the table; per-task storage is not cleared.
module aging_priority_task_selector #(
   parameter int MAX_TASKS  = aps_pkg::MAX_TASKS_DEF,
   parameter int AVG_WINDOW = aps_pkg::AVG_WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // task_id[2:0], static_priority[10:3], period_us[42:11], now_us[74:43]
   input  logic [aps_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // accepted[0], selected_valid[1], selected_task[4:2], waiting_count[8:5],
   // delta_time_us[40:9], moving_delta_sum[72:41]
   output logic [aps_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import aps_pkg::*;

   localparam int DEPTH = (MAX_TASKS < NUM_IDS) ? MAX_TASKS : NUM_IDS;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   // request fields
   logic [ID_W-1:0]   in_id;
   logic [PRIO_W-1:0] in_prio;
   logic [TIME_W-1:0] in_period, in_now;

   assign in_id     = req_tdata[2:0];
   assign in_prio   = req_tdata[10:3];
   assign in_period = req_tdata[42:11];
   assign in_now    = req_tdata[74:43];

   // control state
   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [NUM_IDS-1:0] pres_ff, pres_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // order table, with each entry's static priority alongside
   logic [ID_W-1:0]   list_ff [DEPTH];
   logic [ID_W-1:0]   list_in [DEPTH];
   logic [PRIO_W-1:0] lprio_ff [DEPTH];
   logic [PRIO_W-1:0] lprio_in [DEPTH];

   // per-identifier task storage
   logic [PRIO_W-1:0] prio_ff [NUM_IDS];
   logic [PRIO_W-1:0] prio_in [NUM_IDS];
   logic [TIME_W-1:0] period_ff [NUM_IDS];
   logic [TIME_W-1:0] period_in [NUM_IDS];
   logic [TIME_W-1:0] last_ff [NUM_IDS];
   logic [TIME_W-1:0] last_in [NUM_IDS];
   logic [DYN_W-1:0]  dyn_ff [NUM_IDS];
   logic [DYN_W-1:0]  dyn_in [NUM_IDS];
   logic [TIME_W-1:0] dsum_ff [NUM_IDS];
   logic [TIME_W-1:0] dsum_in [NUM_IDS];

   // schedule walk
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [ID_W-1:0]   cur_ff, cur_in;
   logic [TIME_W-1:0] age_ff, age_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DYN_W-1:0]  best_ff, best_in;
   logic [ID_W-1:0]   sel_ff, sel_in;
   logic              found_ff, found_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;

   // held result
   logic              r_acc_ff, r_acc_in;
   logic              r_sv_ff, r_sv_in;
   logic [ID_W-1:0]   r_task_ff, r_task_in;
   logic [WAIT_W-1:0] r_wait_ff, r_wait_in;
   logic [TIME_W-1:0] r_delta_ff, r_delta_in;
   logic [TIME_W-1:0] r_sum_ff, r_sum_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared divider
   logic              div_start, div_done;
   logic [TIME_W-1:0] div_dividend, div_divisor, div_quo;

   aps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // find insert and remove positions
   logic [CW-1:0] add_pos, rem_pos;
   logic          add_hit;

   always_comb begin
      add_pos = count_ff;
      add_hit = 1'b0;
      rem_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CW'(i) < count_ff && !add_hit && lprio_ff[i] < in_prio) begin
            add_pos = CW'(i);
            add_hit = 1'b1;
         end
         if (CW'(i) < count_ff && list_ff[i] == in_id) begin
            rem_pos = CW'(i);
         end
      end
   end

   logic [ID_W-1:0]   walk_id;
   logic [DYN_W-1:0]  new_dyn, eff_dyn;
   logic [TIME_W:0]   sum_wide;
   logic [TIME_W-1:0] fin_delta;

   assign walk_id = list_ff[idx_ff[IW-1:0]];
   assign new_dyn = (prod_ff >= PROD_W'(65535)) ? {DYN_W{1'b1}}
                                                : prod_ff[DYN_W-1:0] + 1'b1;
   assign eff_dyn = (age_ff != '0) ? new_dyn : dyn_ff[cur_ff];
   assign fin_delta = now_ff - last_ff[sel_ff];
   assign sum_wide  = {1'b0, dsum_ff[sel_ff]} + {1'b0, fin_delta} - {1'b0, div_quo};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pres_in      = pres_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      list_in      = list_ff;
      lprio_in     = lprio_ff;
      prio_in      = prio_ff;
      period_in    = period_ff;
      last_in      = last_ff;
      dyn_in       = dyn_ff;
      dsum_in      = dsum_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      age_in       = age_ff;
      prod_in      = prod_ff;
      best_in      = best_ff;
      sel_in       = sel_ff;
      found_in     = found_ff;
      wait_in      = wait_ff;
      r_acc_in     = r_acc_ff;
      r_sv_in      = r_sv_ff;
      r_task_in    = r_task_ff;
      r_wait_in    = r_wait_ff;
      r_delta_in   = r_delta_ff;
      r_sum_in     = r_sum_ff;
      div_start    = 1'b0;
      div_dividend = now_ff - last_ff[walk_id];
      div_divisor  = period_ff[walk_id];

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               r_acc_in   = 1'b0;
               r_sv_in    = 1'b0;
               r_task_in  = '0;
               r_wait_in  = '0;
               r_delta_in = '0;
               r_sum_in   = '0;
               now_in     = in_now;
               state_in   = ST_DONE;
               case (req_tuser)
                  REQ_ADD: begin
                     if (count_ff < CW'(DEPTH) && !pres_ff[in_id]) begin
                        for (int i = 0; i < DEPTH; i++) begin
                           if (CW'(i) == add_pos) begin
                              list_in[i]  = in_id;
                              lprio_in[i] = in_prio;
                           end else if (CW'(i) > add_pos && i > 0) begin
                              list_in[i]  = list_ff[i-1];
                              lprio_in[i] = lprio_ff[i-1];
                           end
                        end
                        count_in         = count_ff + 1'b1;
                        pres_in[in_id]   = 1'b1;
                        prio_in[in_id]   = in_prio;
                        period_in[in_id] = in_period;
                        last_in[in_id]   = in_now;
                        dyn_in[in_id]    = '0;
                        dsum_in[in_id]   = '0;
                        r_acc_in         = 1'b1;
                     end
                  end
                  REQ_REMOVE: begin
                     if (pres_ff[in_id]) begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                           if (CW'(i) >= rem_pos) begin
                              list_in[i]  = list_ff[i+1];
                              lprio_in[i] = lprio_ff[i+1];
                           end
                        end
                        count_in       = count_ff - 1'b1;
                        pres_in[in_id] = 1'b0;
                        r_acc_in       = 1'b1;
                     end
                  end
                  REQ_SCHED: begin
                     idx_in   = '0;
                     best_in  = '0;
                     sel_in   = '0;
                     found_in = 1'b0;
                     wait_in  = '0;
                     state_in = ST_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            if (idx_ff == count_ff) begin
               r_acc_in  = 1'b1;
               r_wait_in = wait_ff;
               if (found_ff) begin
                  div_start    = 1'b1;
                  div_dividend = dsum_ff[sel_ff];
                  div_divisor  = TIME_W'(AVG_WINDOW);
                  state_in     = ST_FIN;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cur_in = walk_id;
               if (period_ff[walk_id] == '0) begin
                  age_in   = '0;
                  state_in = ST_MUL;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               age_in   = div_quo;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(prio_ff[cur_ff]) * PROD_W'(age_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (age_ff != '0) begin
               dyn_in[cur_ff] = new_dyn;
               wait_in        = wait_ff + 1'b1;
            end
            if (eff_dyn > best_ff) begin
               best_in  = eff_dyn;
               sel_in   = cur_ff;
               found_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = ST_LOAD;
         end
         ST_FIN: begin
            if (div_done) begin
               r_sv_in         = 1'b1;
               r_task_in       = sel_ff;
               r_delta_in      = fin_delta;
               r_sum_in        = sum_wide[TIME_W] ? {TIME_W{1'b1}}
                                                  : sum_wide[TIME_W-1:0];
               dsum_in[sel_ff] = r_sum_in;
               last_in[sel_ff] = now_ff;
               dyn_in[sel_ff]  = '0;
               state_in        = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = RSP_DATA_W'({r_sum_ff, r_delta_ff, r_wait_ff,
                                           r_task_ff, r_sv_ff, r_acc_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pres_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pres_ff      <= pres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      list_ff     <= list_in;
      lprio_ff    <= lprio_in;
      prio_ff     <= prio_in;
      period_ff   <= period_in;
      last_ff     <= last_in;
      dyn_ff      <= dyn_in;
      dsum_ff     <= dsum_in;
      now_ff      <= now_in;
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      age_ff      <= age_in;
      prod_ff     <= prod_in;
      best_ff     <= best_in;
      sel_ff      <= sel_in;
      found_ff    <= found_in;
      wait_ff     <= wait_in;
      r_acc_ff    <= r_acc_in;
      r_sv_ff     <= r_sv_in;
      r_task_ff   <= r_task_in;
      r_wait_ff   <= r_wait_in;
      r_delta_ff  <= r_delta_in;
      r_sum_ff    <= r_sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
